[rtl/arpc_pkg.sv]
// arpc_pkg: shared types and constants for the arp cache and responder
// holds transaction structs, chain token and write structs, codes and state enum
// no dependencies
`timescale 1ns / 1ps

package arpc_pkg;

    // default cache depth
    localparam int DEFAULT_CACHE_ENTRIES = 16;

    // header checks
    localparam logic [10:0] MIN_FRAME_BYTES = 11'd42;
    localparam logic [15:0] HTYPE_ETHERNET  = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4      = 16'h0800;
    localparam logic [7:0]  HW_ADDR_LEN     = 8'd6;
    localparam logic [7:0]  PROTO_ADDR_LEN  = 8'd4;
    localparam logic [15:0] OPCODE_REQUEST  = 16'h0001;

    typedef enum logic
    {
        FUNC_PACKET = 1'b0,
        FUNC_LOOKUP = 1'b1
    } arpc_func_e;

    typedef enum logic
    {
        REG_LOCAL_IP  = 1'b0,
        REG_LOCAL_MAC = 1'b1
    } arpc_reg_e;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } arpc_state_e;

    typedef struct packed
    {
        arpc_func_e  func;
        logic [10:0] frame_length;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [7:0]  hw_len;
        logic [7:0]  proto_len;
        logic [15:0] opcode;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] tgt_ip;
        logic [31:0] lookup_ip;
    } arpc_in_t;

    typedef struct packed
    {
        logic        accepted;
        logic        reply_valid;
        logic [47:0] reply_dest_mac;
        logic [31:0] reply_target_ip;
        logic        lookup_hit;
        logic [47:0] lookup_mac;
    } arpc_out_t;

    // search token passed from cell to cell
    typedef struct packed
    {
        logic        vld;
        logic [31:0] ip;
        logic        hit;
        logic [47:0] hit_mac;
        logic        free;
    } arpc_tok_t;

    // entry write broadcast to the row
    typedef struct packed
    {
        logic        en;
        logic [31:0] ip;
        logic [47:0] mac;
    } arpc_wr_t;

endpackage

[rtl/arp_cache_and_responder_unit.sv]
// arp_cache_and_responder_unit: top level of the arp cache and responder
// depends on arpc_pkg and arpc_cell
`timescale 1ns / 1ps

// ipv4-to-mac cache built as a row of CACHE_ENTRIES cells, one entry per cell.
// each transaction (received arp packet or lookup query) is handled one at a
// time: a search token enters the first cell and moves one cell per clock,
// collecting the first valid entry holding the wanted ip and the first free
// entry. when it leaves the last cell the learned binding is written to the
// chosen cell and the result is built in a holding stage; no new transaction
// is accepted while the token is in the cell row. the result sits in an output
// register; a new transaction is taken once the previous result has left the
// internal holding stage. packets shorter than 42 bytes or with a header other
// than ethernet/ipv4 (6/4 byte addresses) are refused and change nothing. a
// full cache drops new bindings. reset empties the cache at once. local_ip is
// compared with the target ip of requests; local_mac is only the sender
// address of an outgoing reply, which is built outside this block, so it is
// not stored here. configuration is to be written only while the block is
// idle; the block itself does not enforce this.

module arp_cache_and_responder_unit #(
    parameter int CACHE_ENTRIES = arpc_pkg::DEFAULT_CACHE_ENTRIES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  arpc_pkg::arpc_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output arpc_pkg::arpc_out_t out_data,
    input  logic                cfg_we,
    input  arpc_pkg::arpc_reg_e cfg_index,
    input  logic [47:0]         cfg_data
);
    import arpc_pkg::*;

    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

    // state machine
    arpc_state_e state_reg;
    arpc_state_e state_next;

    // configuration
    logic [31:0] local_ip_reg;

    // held transaction and its header verdict
    arpc_in_t item_reg;
    logic     pass_reg;
    logic     reply_reg;
    logic     pass_now;
    logic     reply_now;
    logic     launch_reg;
    logic     take_in;

    // cell row
    arpc_tok_t        tok_c      [CACHE_ENTRIES+1];
    logic [IDX_W-1:0] hit_idx_c  [CACHE_ENTRIES+1];
    logic [IDX_W-1:0] free_idx_c [CACHE_ENTRIES+1];
    arpc_tok_t        tok_end;
    arpc_wr_t         wr;
    logic [IDX_W-1:0] wr_idx;
    logic             is_lookup;

    // result staging and output register
    arpc_out_t res_reg;
    arpc_out_t res_next;
    logic      out_valid_reg;
    arpc_out_t out_data_reg;
    logic      out_free;
    logic      load_out;

    assign take_in = in_valid && in_ready;

    // header checks on the incoming transaction
    always_comb
    begin
        pass_now = (in_data.func == FUNC_PACKET)
                && (in_data.frame_length >= MIN_FRAME_BYTES)
                && (in_data.hw_type == HTYPE_ETHERNET)
                && (in_data.proto_type == PTYPE_IPV4)
                && (in_data.hw_len == HW_ADDR_LEN)
                && (in_data.proto_len == PROTO_ADDR_LEN);
        reply_now = pass_now
                 && (in_data.opcode == OPCODE_REQUEST)
                 && (in_data.tgt_ip == local_ip_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg <= '0;
        end
        else if (cfg_we && (cfg_index == REG_LOCAL_IP))
        begin
            local_ip_reg <= cfg_data[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            item_reg  <= in_data;
            pass_reg  <= pass_now;
            reply_reg <= reply_now;
        end
    end

    // launch pulse puts the search token into the first cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launch_reg <= 1'b0;
        end
        else
        begin
            launch_reg <= take_in;
        end
    end

    assign is_lookup = (item_reg.func == FUNC_LOOKUP);

    always_comb
    begin
        tok_c[0]         = '0;
        tok_c[0].vld     = launch_reg;
        tok_c[0].ip      = is_lookup ? item_reg.lookup_ip : item_reg.sender_ip;
        hit_idx_c[0]     = '0;
        free_idx_c[0]    = '0;
    end

    for (genvar i = 0; i < CACHE_ENTRIES; i++)
    begin : g_cell
        arpc_cell #(
            .IDX_W (IDX_W),
            .INDEX (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .tok_in       (tok_c[i]),
            .hit_idx_in   (hit_idx_c[i]),
            .free_idx_in  (free_idx_c[i]),
            .tok_out      (tok_c[i+1]),
            .hit_idx_out  (hit_idx_c[i+1]),
            .free_idx_out (free_idx_c[i+1]),
            .wr           (wr),
            .wr_idx       (wr_idx)
        );
    end

    assign tok_end = tok_c[CACHE_ENTRIES];

    // learn on token exit: existing binding first, else first free entry
    always_comb
    begin
        wr.en  = tok_end.vld && pass_reg && (tok_end.hit || tok_end.free);
        wr.ip  = item_reg.sender_ip;
        wr.mac = item_reg.sender_mac;
        wr_idx = tok_end.hit ? hit_idx_c[CACHE_ENTRIES] : free_idx_c[CACHE_ENTRIES];
    end

    // result of the transaction as the token leaves the row
    always_comb
    begin
        res_next                 = '0;
        res_next.accepted        = pass_reg;
        res_next.reply_valid     = reply_reg;
        if (reply_reg)
        begin
            res_next.reply_dest_mac  = item_reg.sender_mac;
            res_next.reply_target_ip = item_reg.sender_ip;
        end
        if (is_lookup && tok_end.hit)
        begin
            res_next.lookup_hit = 1'b1;
            res_next.lookup_mac = tok_end.hit_mac;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_end.vld)
        begin
            res_reg <= res_next;
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (tok_end.vld)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_SCAN:
            begin
                in_ready = 1'b0;
            end
            ST_FINISH:
            begin
                load_out = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[rtl/arpc_cell.sv]
// arpc_cell: one cache entry plus one stage of the search chain
// depends on arpc_pkg
`timescale 1ns / 1ps

module arpc_cell #(
    parameter int IDX_W = 4,
    parameter int INDEX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  arpc_pkg::arpc_tok_t tok_in,
    input  logic [IDX_W-1:0]    hit_idx_in,
    input  logic [IDX_W-1:0]    free_idx_in,
    output arpc_pkg::arpc_tok_t tok_out,
    output logic [IDX_W-1:0]    hit_idx_out,
    output logic [IDX_W-1:0]    free_idx_out,
    input  arpc_pkg::arpc_wr_t  wr,
    input  logic [IDX_W-1:0]    wr_idx
);
    import arpc_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic             valid_reg;
    logic [31:0]      ip_reg;
    logic [47:0]      mac_reg;
    arpc_tok_t        tok_reg;
    arpc_tok_t        tok_next;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [IDX_W-1:0] hit_idx_next;
    logic [IDX_W-1:0] free_idx_reg;
    logic [IDX_W-1:0] free_idx_next;
    logic             match;
    logic             wr_here;

    assign match   = valid_reg && (ip_reg == tok_in.ip);
    assign wr_here = wr.en && (wr_idx == MY_IDX);

    // first match and first free slot win
    always_comb
    begin
        tok_next      = tok_in;
        hit_idx_next  = hit_idx_in;
        free_idx_next = free_idx_in;
        if (!tok_in.hit && match)
        begin
            tok_next.hit     = 1'b1;
            tok_next.hit_mac = mac_reg;
            hit_idx_next     = MY_IDX;
        end
        if (!tok_in.free && !valid_reg)
        begin
            tok_next.free = 1'b1;
            free_idx_next = MY_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (wr_here)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        if (wr_here)
        begin
            ip_reg  <= wr.ip;
            mac_reg <= wr.mac;
        end
    end

    assign tok_out      = tok_reg;
    assign hit_idx_out  = hit_idx_reg;
    assign free_idx_out = free_idx_reg;

endmodule
